### src/irql_pkg.sv
// Shared types and constants of the interrupt-disabled span recorder.
// No dependencies; every other file of the block refers to it by scoped names.
package irql_pkg;

  // Event codes carried in the action field.
  localparam logic [1:0] ACT_OFF    = 2'd0;
  localparam logic [1:0] ACT_ON     = 2'd1;
  localparam logic [1:0] ACT_IGNORE = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT = 2'd1;

  localparam int unsigned THRESH_W     = 20;
  localparam int unsigned REC_CNT_W    = 4;
  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned THRESH_NS_W  = 30;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned RIDX_W       = 3;
  localparam int unsigned STORED_CNT_W = 4;

  localparam logic [THRESH_NS_W-1:0] NS_PER_US          = 30'd1000;
  localparam logic [REC_CNT_W-1:0]   RESET_RECORD_COUNT = 4'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted input item
    logic exec;    // form the span and read the addressed ring entry
    logic commit;  // update state and load the result register
  } dp_cmd_t;

endpackage

### src/irql_if.sv
// Valid/ready channel interfaces for the event input and the result output.
// Depends on irql_pkg for field widths.
interface irql_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic [irql_pkg::WORD_W-1:0]     timestamp_ns;
  logic [irql_pkg::WORD_W-1:0]     caller_addr;
  logic [irql_pkg::RIDX_W-1:0]     read_index;

  modport source (output valid, action, timestamp_ns, caller_addr, read_index, input ready);
  modport sink   (input valid, action, timestamp_ns, caller_addr, read_index, output ready);
endinterface

interface irql_out_if;
  logic                              valid;
  logic                              ready;
  logic                              recorded;
  logic [irql_pkg::WORD_W-1:0]       entry_span_ns;
  logic [irql_pkg::WORD_W-1:0]       entry_caller;
  logic [irql_pkg::STORED_CNT_W-1:0] stored_count;

  modport source (output valid, recorded, entry_span_ns, entry_caller, stored_count,
                  input ready);
  modport sink   (input valid, recorded, entry_span_ns, entry_caller, stored_count,
                  output ready);
endinterface

### src/irql_ctrl.sv
// Sequencing controller of the span recorder: accept, execute, commit.
// Depends on irql_pkg for the command struct.
module irql_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output irql_pkg::dp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted transfer did not start execution");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result became valid without a commit");

endmodule

### src/irql_datapath.sv
// Datapath of the span recorder: configuration, armed state, span arithmetic,
// record rings with per-entry valid bits and the result register. Uses irql_pkg.
module irql_datapath #(
  parameter int unsigned MAX_RECORDS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [irql_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [irql_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  irql_pkg::dp_cmd_t                   cmd_i,
  input  logic [1:0]                          action_i,
  input  logic [irql_pkg::WORD_W-1:0]         timestamp_ns_i,
  input  logic [irql_pkg::WORD_W-1:0]         caller_addr_i,
  input  logic [irql_pkg::RIDX_W-1:0]         read_index_i,
  output logic                                recorded_o,
  output logic [irql_pkg::WORD_W-1:0]         entry_span_ns_o,
  output logic [irql_pkg::WORD_W-1:0]         entry_caller_o,
  output logic [irql_pkg::STORED_CNT_W-1:0]   stored_count_o
);

  localparam int unsigned IdxW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_RECORDS + 1);
  localparam int unsigned AddrW = (IdxW > irql_pkg::RIDX_W) ? IdxW : irql_pkg::RIDX_W;
  localparam int unsigned WW    = irql_pkg::WORD_W;

  // Configuration and monitor state.
  logic [irql_pkg::THRESH_NS_W-1:0] thr_ns_q;
  logic [irql_pkg::REC_CNT_W-1:0]   rec_cnt_q;
  logic                             armed_q;
  logic [WW-1:0]                    start_q;
  logic [MAX_RECORDS-1:0]           valid_q;
  logic [IdxW-1:0]                  wr_pos_q, wr_pos_d;
  logic [CntW-1:0]                  vcnt_q, vcnt_d;

  // Captured item and intermediate results.
  logic [1:0]                   act_q;
  logic [WW-1:0]                ts_q, caller_q, span_q;
  logic [irql_pkg::RIDX_W-1:0]  ridx_q;
  logic [WW-1:0]                rd_span_q, rd_caller_q;
  logic                         rd_ok_q;

  // Record rings.
  logic [WW-1:0] span_mem   [MAX_RECORDS];
  logic [WW-1:0] caller_mem [MAX_RECORDS];

  // Result register.
  logic                               out_rec_q;
  logic [WW-1:0]                      out_span_q, out_caller_q;
  logic [irql_pkg::STORED_CNT_W-1:0]  out_count_q;

  logic [7:0]      rc_w, n_w, vc_w;
  logic [CntW-1:0] n_ring, pos_w, pos_inc;
  logic [AddrW-1:0] ridx_ext;
  logic            enabled, do_arm, do_disarm, hit, is_read, cfg_hit;

  // Ring size in use: zero acts as one, and it is capped at the ring depth.
  always_comb begin
    rc_w = 8'(rec_cnt_q);
    if (rc_w == 8'd0) begin
      n_w = 8'd1;
    end else if (rc_w > 8'(MAX_RECORDS)) begin
      n_w = 8'(MAX_RECORDS);
    end else begin
      n_w = rc_w;
    end
  end
  assign n_ring = n_w[CntW-1:0];

  assign ridx_ext = AddrW'(ridx_q);
  assign enabled  = (thr_ns_q != '0);

  always_comb begin
    do_arm    = 1'b0;
    do_disarm = 1'b0;
    hit       = 1'b0;
    is_read   = 1'b0;
    unique case (act_q)
      irql_pkg::ACT_OFF: begin
        do_arm = enabled && !armed_q;
      end
      irql_pkg::ACT_ON: begin
        do_disarm = enabled;
        hit       = enabled && armed_q &&
                    (span_q > {{(WW - irql_pkg::THRESH_NS_W){1'b0}}, thr_ns_q});
      end
      irql_pkg::ACT_IGNORE: begin
        do_disarm = enabled;
      end
      irql_pkg::ACT_READ: begin
        is_read = 1'b1;
      end
      default: begin
        is_read = 1'b0;
      end
    endcase
  end

  // Write position, falling back to entry zero if it lies beyond the ring size.
  always_comb begin
    pos_w    = (CntW'(wr_pos_q) < n_ring) ? CntW'(wr_pos_q) : '0;
    pos_inc  = pos_w + 1'b1;
    wr_pos_d = (pos_inc == n_ring) ? '0 : pos_inc[IdxW-1:0];
    vcnt_d   = vcnt_q;
    if (hit) begin
      vcnt_d = (vcnt_q >= n_ring) ? n_ring : vcnt_q + 1'b1;
    end
  end
  assign vc_w = 8'(vcnt_d);

  assign cfg_hit = cfg_we_i &&
                   ((cfg_idx_i == irql_pkg::CFG_THRESHOLD) ||
                    (cfg_idx_i == irql_pkg::CFG_RECORD_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_ns_q  <= '0;
      rec_cnt_q <= irql_pkg::RESET_RECORD_COUNT;
      armed_q   <= 1'b0;
      valid_q   <= '0;
      wr_pos_q  <= '0;
      vcnt_q    <= '0;
    end else if (cfg_hit) begin
      if (cfg_idx_i == irql_pkg::CFG_THRESHOLD) begin
        thr_ns_q <= irql_pkg::THRESH_NS_W'(cfg_data_i[irql_pkg::THRESH_W-1:0]) *
                    irql_pkg::NS_PER_US;
      end else begin
        rec_cnt_q <= cfg_data_i[irql_pkg::REC_CNT_W-1:0];
      end
      armed_q  <= 1'b0;
      valid_q  <= '0;
      wr_pos_q <= '0;
      vcnt_q   <= '0;
    end else if (cmd_i.commit) begin
      if (do_arm) begin
        armed_q <= 1'b1;
      end else if (do_disarm) begin
        armed_q <= 1'b0;
      end
      if (hit) begin
        valid_q[pos_w[IdxW-1:0]] <= 1'b1;
        wr_pos_q                 <= wr_pos_d;
        vcnt_q                   <= vcnt_d;
      end
    end
  end

  // Payload registers, captured under command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      ts_q     <= timestamp_ns_i;
      caller_q <= caller_addr_i;
      ridx_q   <= read_index_i;
    end
    if (cmd_i.exec) begin
      span_q  <= ts_q - start_q;
      rd_ok_q <= (8'(ridx_q) < 8'(n_ring)) && valid_q[ridx_ext[IdxW-1:0]];
    end
    if (cmd_i.commit && do_arm) begin
      start_q <= ts_q;
    end
    if (cmd_i.commit) begin
      out_rec_q    <= hit;
      out_span_q   <= (is_read && rd_ok_q) ? rd_span_q : '0;
      out_caller_q <= (is_read && rd_ok_q) ? rd_caller_q : '0;
      out_count_q  <= vc_w[irql_pkg::STORED_CNT_W-1:0];
    end
  end

  // Ring memories: one write port at commit, one registered read port at exec.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && hit) begin
      span_mem[pos_w[IdxW-1:0]]   <= span_q;
      caller_mem[pos_w[IdxW-1:0]] <= caller_q;
    end
    if (cmd_i.exec) begin
      rd_span_q   <= span_mem[ridx_ext[IdxW-1:0]];
      rd_caller_q <= caller_mem[ridx_ext[IdxW-1:0]];
    end
  end

  assign recorded_o      = out_rec_q;
  assign entry_span_ns_o = out_span_q;
  assign entry_caller_o  = out_caller_q;
  assign stored_count_o  = out_count_q;

  a_count_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= n_ring)
    else $error("stored count exceeds ring size");

  a_pos_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(wr_pos_q) < n_ring)
    else $error("write position outside ring");

  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(vcnt_q))
    else $error("valid entries disagree with stored count");

endmodule

### src/irqs_off_latency_recorder.sv
// Interrupt-disabled span recorder. Each event transfer passes through an
// accept state, an execute state that forms the 64-bit span and reads the
// addressed ring entry from the registered memory port, and a commit state
// that updates the armed state and the ring and loads the result register.
// A new event is accepted only once the last one has committed. A result
// waiting in the output register does not block acceptance of the next event;
// only the commit of that next event waits until the earlier result has been
// taken. The ring holds MAX_RECORDS entries, each with a valid bit, so a write
// to the threshold or record-count configuration register clears it.
module irqs_off_latency_recorder #(
  parameter int unsigned MAX_RECORDS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [irql_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [irql_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  irql_in_if.sink                           event_i,
  irql_out_if.source                        result_o
);

  irql_pkg::dp_cmd_t cmd;

  irql_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (event_i.valid),
    .in_ready_o  (event_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .cmd_o       (cmd)
  );

  irql_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .action_i        (event_i.action),
    .timestamp_ns_i  (event_i.timestamp_ns),
    .caller_addr_i   (event_i.caller_addr),
    .read_index_i    (event_i.read_index),
    .recorded_o      (result_o.recorded),
    .entry_span_ns_o (result_o.entry_span_ns),
    .entry_caller_o  (result_o.entry_caller),
    .stored_count_o  (result_o.stored_count)
  );

endmodule
